// File: design/dlee_pkg.sv
// Package for the DLE escape frame encoder.
// Holds the register reset values, register indexes and the types shared by
// the front, queue and back modules. No dependencies.
package dlee_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] DELIM_RESET  = 8'h10;
  localparam logic [7:0] ESC_RESET    = 8'h1B;
  localparam logic       APPEND_RESET = 1'b1;

  localparam logic [7:0] BIT5_FLIP = 8'h20;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESC    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_APPEND = 2'd2;

  // Codes the back end needs to build line bytes.
  typedef struct packed {
    logic [7:0] delim;
    logic [7:0] esc;
  } cfg_t;

  // One classified message byte, as the front end hands it on.
  typedef struct packed {
    logic       open;
    logic [7:0] data;
    logic       data_esc;
    logic       last;
    logic       cks_en;
    logic [7:0] cks;
    logic       cks_esc;
  } job_t;

endpackage

// File: design/dlee_front.sv
// Front end of the DLE escape frame encoder: configuration registers,
// input acceptance and classification of each byte. Depends on dlee_pkg.
module dlee_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last_byte,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dlee_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           q_full,
  output logic                           q_push,
  output dlee_pkg::job_t                 q_job,
  output dlee_pkg::cfg_t                 cfg
);

  logic [7:0] delim_r;
  logic [7:0] esc_r;
  logic       append_r;
  logic       inside_frame_r;
  logic       inside_frame_nxt;
  logic [7:0] message_xor_r;
  logic [7:0] message_xor_nxt;
  logic [7:0] mx;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign q_push    = in_valid && in_ready;

  assign cfg.delim = delim_r;
  assign cfg.esc   = esc_r;

  // A new frame starts its message checksum from zero.
  assign mx = (inside_frame_r ? message_xor_r : 8'h00) ^ in_data_byte;

  always_comb begin
    q_job.open     = !inside_frame_r;
    q_job.data     = in_data_byte;
    q_job.data_esc = (in_data_byte == delim_r) || (in_data_byte == esc_r);
    q_job.last     = in_last_byte;
    q_job.cks_en   = append_r;
    q_job.cks      = mx;
    q_job.cks_esc  = (mx == delim_r) || (mx == esc_r);
  end

  always_comb begin
    inside_frame_nxt = inside_frame_r;
    message_xor_nxt  = message_xor_r;
    if (q_push) begin
      inside_frame_nxt = !in_last_byte;
      message_xor_nxt  = in_last_byte ? 8'h00 : mx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r        <= dlee_pkg::DELIM_RESET;
      esc_r          <= dlee_pkg::ESC_RESET;
      append_r       <= dlee_pkg::APPEND_RESET;
      inside_frame_r <= 1'b0;
      message_xor_r  <= 8'h00;
    end else begin
      inside_frame_r <= inside_frame_nxt;
      message_xor_r  <= message_xor_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          dlee_pkg::REG_DELIM:  delim_r  <= cfg_data;
          dlee_pkg::REG_ESC:    esc_r    <= cfg_data;
          dlee_pkg::REG_APPEND: append_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: design/dlee_queue.sv
// Short queue of classified items between the front and back ends.
// Flip-flop storage, first in first out. Depends on dlee_pkg.
module dlee_queue #(
  parameter int QUEUE_DEPTH = dlee_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dlee_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output dlee_pkg::job_t pop_job,
  output logic           empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  dlee_pkg::job_t   slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: design/dlee_back.sv
// Back end of the DLE escape frame encoder: steps through the line bytes of
// the item at the queue head, keeps the line checksum and drives the output
// register. Depends on dlee_pkg.
module dlee_back (
  input  logic           clk,
  input  logic           rst_n,
  input  dlee_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  dlee_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_line_byte,
  output logic           out_run_last,
  output logic           out_frame_end
);

  localparam logic [2:0] ST_OPEN  = 3'd0;
  localparam logic [2:0] ST_DESC  = 3'd1;
  localparam logic [2:0] ST_DATA  = 3'd2;
  localparam logic [2:0] ST_CESC  = 3'd3;
  localparam logic [2:0] ST_CKS   = 3'd4;
  localparam logic [2:0] ST_LXOR  = 3'd5;
  localparam logic [2:0] ST_CLOSE = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic       busy_r;
  logic [2:0] step_r;
  logic [7:0] line_xor_r;
  logic [7:0] line_xor_nxt;
  logic       out_valid_r;
  logic [7:0] line_byte_r;
  logic       run_last_r;
  logic       frame_end_r;

  logic [2:0] first_step;
  logic [2:0] cur;
  logic [2:0] nxt;
  logic [7:0] byte_val;
  logic       advance;

  assign first_step = q_job.open ? ST_OPEN : (q_job.data_esc ? ST_DESC : ST_DATA);
  assign cur        = busy_r ? step_r : first_step;
  assign advance    = !q_empty && (!out_valid_r || out_ready);
  assign q_pop      = advance && (nxt == ST_DONE);

  always_comb begin
    byte_val = 8'h00;
    nxt      = ST_DONE;
    unique case (cur)
      ST_OPEN: begin
        byte_val = cfg.delim;
        nxt      = q_job.data_esc ? ST_DESC : ST_DATA;
      end
      ST_DESC: begin
        byte_val = cfg.esc;
        nxt      = ST_DATA;
      end
      ST_DATA: begin
        byte_val = q_job.data_esc ? (q_job.data ^ dlee_pkg::BIT5_FLIP) : q_job.data;
        if (!q_job.last) begin
          nxt = ST_DONE;
        end else if (q_job.cks_en) begin
          nxt = q_job.cks_esc ? ST_CESC : ST_CKS;
        end else begin
          nxt = ST_LXOR;
        end
      end
      ST_CESC: begin
        byte_val = cfg.esc;
        nxt      = ST_CKS;
      end
      ST_CKS: begin
        byte_val = q_job.cks_esc ? (q_job.cks ^ dlee_pkg::BIT5_FLIP) : q_job.cks;
        nxt      = ST_LXOR;
      end
      ST_LXOR: begin
        byte_val = line_xor_r;
        nxt      = ST_CLOSE;
      end
      ST_CLOSE: begin
        byte_val = cfg.delim;
        nxt      = ST_DONE;
      end
      default: begin
        byte_val = 8'h00;
        nxt      = ST_DONE;
      end
    endcase
  end

  // The opener restarts the line checksum; after the closer it is cleared.
  always_comb begin
    if (cur == ST_OPEN) begin
      line_xor_nxt = cfg.delim;
    end else if (cur == ST_CLOSE) begin
      line_xor_nxt = 8'h00;
    end else begin
      line_xor_nxt = line_xor_r ^ byte_val;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      line_byte_r <= byte_val;
      run_last_r  <= (nxt == ST_DONE);
      frame_end_r <= (cur == ST_CLOSE);
      step_r      <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      line_xor_r  <= 8'h00;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      busy_r      <= (nxt != ST_DONE);
      line_xor_r  <= line_xor_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_line_byte = line_byte_r;
  assign out_run_last  = run_last_r;
  assign out_frame_end = frame_end_r;

endmodule

// File: design/dle_escape_frame_encoder_top.sv
// Top level of the DLE escape frame encoder: front end, item queue, back end.
// An accepted item is first written into a queue slot; the back end then registers each of its
// line bytes in the output register, the first of them once the item reaches the queue head.
// Each item gives 1 to 7 line bytes, one line byte per cycle while the output is not stalled;
// a plain byte inside a frame gives one line byte, an escaped byte two, trailer bytes one each.
// Reset (rst_n, synchronous): no frame open, checksums zero, queue empty, registers at defaults.
module dle_escape_frame_encoder_top #(
  parameter int QUEUE_DEPTH = dlee_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_line_byte,
  output logic                           out_run_last,
  output logic                           out_frame_end,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dlee_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  dlee_pkg::job_t push_job;
  dlee_pkg::job_t head_job;
  dlee_pkg::cfg_t cfg;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;

  dlee_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (push_job),
    .cfg          (cfg)
  );

  dlee_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (head_job),
    .empty    (q_empty)
  );

  dlee_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_job         (head_job),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_line_byte (out_line_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

endmodule

// File: design/dlee_checker.sv
// Port-level checks for the DLE escape frame encoder, bound to the top level.
// Looks only at the top level's handshake and payload ports; no other dependencies.
module dlee_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_data_byte,
  input logic       in_last_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_line_byte,
  input logic       out_run_last,
  input logic       out_frame_end,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // A stalled result item keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_byte)
      && $stable(out_run_last) && $stable(out_frame_end))
    else $error("result item changed while stalled");

  // An input item that is waiting keeps its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data_byte) && $stable(in_last_byte))
    else $error("input item changed while waiting");

  // The closing delimiter is always the last byte of its item.
  a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_run_last)
    else $error("closing delimiter not marked as last of its item");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // The configuration port never stalls.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind dle_escape_frame_encoder_top dlee_checker u_dlee_checker (.*);
